/* design/fpr_pkg.sv */
// Shared widths, register indexes, reset values and the status type for the page replacement unit.
`default_nettype none

package fpr_pkg;

  // Default values for the top-level parameters.
  localparam int MAX_FRAMES_DEF   = 16;
  localparam int ADDRESS_BITS_DEF = 32;

  // Fixed field widths.
  localparam int PAGE_BYTES_W = 17;
  localparam int FRAMES_W     = 5;
  localparam int FRAME_W      = 4;
  localparam int COUNT_W      = 32;
  localparam int PAGE_BASE_W  = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = PAGE_BYTES_W;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 1'd1;

  localparam logic [PAGE_BYTES_W-1:0] PAGE_BYTES_RESET    = 17'd4096;
  localparam logic [FRAMES_W-1:0]     FRAMES_IN_USE_RESET = 5'd16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Status of the remainder unit toward the sequencer.
  typedef struct packed {
    logic                    done;
    logic [PAGE_BYTES_W-1:0] rem;
  } rem_status_t;

endpackage

`default_nettype wire

/* design/fifo_page_replacement_unit.sv */
// Top level of the FIFO page replacement unit: sequencer, counters and result register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | in_valid / in_ready    | address
//  out     | output    | out_valid / out_ready  | fault, frame, page_base, totals
//  cfg     | input     | cfg_write (no wait)    | cfg_index, cfg_data
//
// From acceptance to result, the remainder unit works through the address one bit at a
// time while the frame scan reads one memory entry per cycle in parallel; the write-back
// state then writes the result register and, on a fault, the table. Reset clears the
// counters, the pointer and all valid bits; page bases are not cleared. A stalled result
// holds the sequencer in its write-back state.
`default_nettype none

module fifo_page_replacement_unit #(
  parameter int MAX_FRAMES   = fpr_pkg::MAX_FRAMES_DEF,
  parameter int ADDRESS_BITS = fpr_pkg::ADDRESS_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [ADDRESS_BITS-1:0]          address,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             fault,
  output logic [fpr_pkg::FRAME_W-1:0]      frame,
  output logic [fpr_pkg::PAGE_BASE_W-1:0]  page_base,
  output logic [fpr_pkg::COUNT_W-1:0]      fault_total,
  output logic [fpr_pkg::COUNT_W-1:0]      reference_total,
  input  wire                              cfg_write,
  input  wire  [fpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [fpr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NW_MIN = $clog2(MAX_FRAMES + 1);
  localparam int NW     = (NW_MIN > fpr_pkg::FRAMES_W) ? NW_MIN : fpr_pkg::FRAMES_W;
  localparam int PW     = fpr_pkg::PAGE_BYTES_W;
  localparam int CW     = fpr_pkg::COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  state_t state;

  // Configuration registers.
  logic [PW-1:0]                page_bytes;
  logic [fpr_pkg::FRAMES_W-1:0] frames_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_bytes    <= fpr_pkg::PAGE_BYTES_RESET;
      frames_in_use <= fpr_pkg::FRAMES_IN_USE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        fpr_pkg::CFG_PAGE_BYTES:    page_bytes    <= cfg_data;
        fpr_pkg::CFG_FRAMES_IN_USE: frames_in_use <= cfg_data[fpr_pkg::FRAMES_W-1:0];
        default:                    ;
      endcase
    end
  end

  // Effective page size and rotation length.
  logic [PW-1:0] psize_eff;
  logic [NW-1:0] n_raw;
  logic [NW-1:0] n_eff;

  assign psize_eff = (page_bytes == '0) ? PW'(1) : page_bytes;
  assign n_raw     = (frames_in_use == '0) ? NW'(1) : NW'(frames_in_use);
  assign n_eff     = (n_raw > NW'(MAX_FRAMES)) ? NW'(MAX_FRAMES) : n_raw;

  // Per-word registers captured at acceptance.
  logic [ADDRESS_BITS-1:0] addr;
  logic [PW-1:0]           psize;
  logic [NW-1:0]           n;

  // Scan pipeline: issue index, compare stage and first match.
  logic [NW-1:0]    scan_issue;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic             found;
  logic [IDX_W-1:0] hit_idx;

  // Persistent state.
  logic [fpr_pkg::FRAME_W-1:0] next_frame;
  logic [CW-1:0]               fault_count;
  logic [CW-1:0]               reference_count;

  logic                  accept;
  logic                  issue;
  logic                  scan_done;
  logic                  out_free;
  logic                  commit;
  fpr_pkg::rem_status_t  div_stat;
  logic [ADDRESS_BITS-1:0] rd_data;
  logic                    rd_valid;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign issue    = (state == S_SEARCH) && (scan_issue < n) && !found;
  assign out_free = !out_valid || out_ready;
  assign commit   = (state == S_UPDATE) && out_free;
  assign scan_done = found || ((scan_issue == n) && !cmp_valid);

  // Match test: address lies within [base, base + page size).
  logic [ADDRESS_BITS:0] diff;
  logic [63:0]           diff64;
  logic                  hit_now;

  assign diff    = {1'b0, addr} - {1'b0, rd_data};
  assign diff64  = 64'(diff[ADDRESS_BITS-1:0]);
  assign hit_now = cmp_valid && rd_valid && !diff[ADDRESS_BITS] && (diff64 < 64'(psize));

  // Fill decision and pointer advance.
  logic [IDX_W-1:0]            used;
  logic [NW-1:0]               used_inc;
  logic [fpr_pkg::FRAME_W-1:0] next_frame_next;
  logic [CW-1:0]               fault_count_next;
  logic [CW-1:0]               reference_count_next;
  logic [ADDRESS_BITS-1:0]     base;
  logic [63:0]                 base64;

  always_comb begin
    if (found) begin
      used = hit_idx;
    end else if (NW'(next_frame) < n) begin
      used = IDX_W'(next_frame);
    end else begin
      used = '0;
    end
    used_inc = NW'(used) + NW'(1);
    next_frame_next = (used_inc >= n) ? '0 : fpr_pkg::FRAME_W'(used_inc);
    reference_count_next = (reference_count == fpr_pkg::COUNT_MAX) ?
                           reference_count : reference_count + CW'(1);
    fault_count_next = (fault_count == fpr_pkg::COUNT_MAX) ?
                       fault_count : fault_count + CW'(1);
    base   = addr - ADDRESS_BITS'(div_stat.rem);
    base64 = 64'(base);
  end

  // Sequencer. Table writes happen only in the write-back cycle, never during a
  // scan, so reads and writes to the same frame cannot overlap.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      next_frame      <= '0;
      fault_count     <= '0;
      reference_count <= '0;
      cmp_valid       <= 1'b0;
      found           <= 1'b0;
      scan_issue      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state      <= S_SEARCH;
            scan_issue <= '0;
            cmp_valid  <= 1'b0;
            found      <= 1'b0;
          end
        end
        S_SEARCH: begin
          cmp_valid <= issue;
          if (issue) begin
            scan_issue <= scan_issue + NW'(1);
          end
          if (hit_now && !found) begin
            found <= 1'b1;
          end
          if (div_stat.done && scan_done) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (out_free) begin
            state           <= S_IDLE;
            reference_count <= reference_count_next;
            if (!found) begin
              next_frame  <= next_frame_next;
              fault_count <= fault_count_next;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result valid flag: set on write-back, cleared once the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Per-word payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      addr  <= address;
      psize <= psize_eff;
      n     <= n_eff;
    end
    if (issue) begin
      cmp_idx <= scan_issue[IDX_W-1:0];
    end
    if ((state == S_SEARCH) && hit_now && !found) begin
      hit_idx <= cmp_idx;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (commit) begin
      fault           <= !found;
      frame           <= fpr_pkg::FRAME_W'(used);
      page_base       <= base64[fpr_pkg::PAGE_BASE_W-1:0];
      fault_total     <= found ? fault_count : fault_count_next;
      reference_total <= reference_count_next;
    end
  end

  fpr_rem_unit #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (address),
    .divisor  (psize_eff),
    .stat     (div_stat)
  );

  fpr_frame_store #(
    .MAX_FRAMES  (MAX_FRAMES),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (issue),
    .rd_idx   (scan_issue[IDX_W-1:0]),
    .rd_data  (rd_data),
    .rd_valid (rd_valid),
    .wr_en    (commit && !found),
    .wr_idx   (used),
    .wr_data  (base)
  );

`ifndef ASSERT_OFF
  // Write-back only starts once the remainder is final.
  a_update_needs_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE) |-> div_stat.done)
    else $error("write-back entered before the remainder was ready");

  // A matching frame is always inside the rotation.
  a_hit_in_rotation: assert property (@(posedge clk) disable iff (rst)
    found |-> (NW'(hit_idx) < n))
    else $error("matched frame lies outside the rotation");

  // An accepted word blocks further input until its result is written back.
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input accepted while a word is in flight");

  // A committed result always presents valid output on the next cycle.
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("committed result not presented");
`endif

endmodule

`default_nettype wire

/* design/fpr_rem_unit.sv */
// Restoring remainder unit: address modulo page size, one dividend bit per cycle.
`default_nettype none

module fpr_rem_unit #(
  parameter int ADDRESS_BITS = fpr_pkg::ADDRESS_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  input  wire  [ADDRESS_BITS-1:0]          dividend,
  input  wire  [fpr_pkg::PAGE_BYTES_W-1:0] divisor,
  output fpr_pkg::rem_status_t             stat
);

  localparam int CNT_W = $clog2(ADDRESS_BITS + 1);
  localparam int PW    = fpr_pkg::PAGE_BYTES_W;

  logic [ADDRESS_BITS-1:0] shreg;
  logic [PW-1:0]           rem;
  logic [PW-1:0]           dvsr;
  logic [CNT_W-1:0]        cnt;
  logic                    busy;
  logic                    done;
  logic [PW:0]             trial;
  logic [PW:0]             trial_sub;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial     = {rem, shreg[ADDRESS_BITS-1]};
  assign trial_sub = trial - {1'b0, dvsr};

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(ADDRESS_BITS);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      dvsr  <= divisor;
    end else if (busy) begin
      shreg <= {shreg[ADDRESS_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dvsr}) begin
        rem <= trial_sub[PW-1:0];
      end else begin
        rem <= trial[PW-1:0];
      end
    end
  end

  assign stat.done = done;
  assign stat.rem  = rem;

`ifndef ASSERT_OFF
  // A new start always withdraws the previous result.
  a_start_clears_done: assert property (@(posedge clk) disable iff (rst)
    start |=> !done && busy)
    else $error("remainder unit reports done right after a start");

  // The unit is never busy and done at the same time.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("remainder unit is busy and done together");

  // While busy, steps are still left to run.
  a_busy_has_steps: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt != '0))
    else $error("remainder unit busy with no steps left");
`endif

endmodule

`default_nettype wire

/* design/fpr_frame_store.sv */
// Frame table: page bases in a synchronous memory, valid bits in flip-flops.
`default_nettype none

module fpr_frame_store #(
  parameter int MAX_FRAMES   = fpr_pkg::MAX_FRAMES_DEF,
  parameter int ADDRESS_BITS = fpr_pkg::ADDRESS_BITS_DEF
) (
  input  wire                                                   clk,
  input  wire                                                   rst,
  input  wire                                                   rd_en,
  input  wire  [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] rd_idx,
  output logic [ADDRESS_BITS-1:0]                               rd_data,
  output logic                                                  rd_valid,
  input  wire                                                   wr_en,
  input  wire  [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] wr_idx,
  input  wire  [ADDRESS_BITS-1:0]                               wr_data
);

  logic [ADDRESS_BITS-1:0] mem [MAX_FRAMES];
  logic [MAX_FRAMES-1:0]   valid;

  // Base memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  // Valid bits follow the memory with the same read latency.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_idx];
      end
    end
  end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the FIFO page replacement unit with a built-in page table predictor.

module testbench;

  localparam int FRAMES_MAX     = fpr_pkg::MAX_FRAMES_DEF;
  localparam int ADDR_W         = fpr_pkg::ADDRESS_BITS_DEF;
  localparam int RANDOM_WORDS   = 1850;
  localparam int WATCHDOG_LIMIT = 4000;

  // One expected lookup result.
  typedef struct packed {
    logic                            fault;
    logic [fpr_pkg::FRAME_W-1:0]     frame;
    logic [fpr_pkg::PAGE_BASE_W-1:0] base;
    logic [fpr_pkg::COUNT_W-1:0]     faults;
    logic [fpr_pkg::COUNT_W-1:0]     refs;
  } lookup_t;

  logic clk;
  logic rst = 1'b1;

  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [ADDR_W-1:0]               address = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            fault;
  logic [fpr_pkg::FRAME_W-1:0]     frame;
  logic [fpr_pkg::PAGE_BASE_W-1:0] page_base;
  logic [fpr_pkg::COUNT_W-1:0]     fault_total;
  logic [fpr_pkg::COUNT_W-1:0]     reference_total;
  logic                            cfg_write = 1'b0;
  logic [fpr_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [fpr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // Shadow copies of the configuration registers.
  logic [fpr_pkg::PAGE_BYTES_W-1:0] shadow_page_bytes = fpr_pkg::PAGE_BYTES_RESET;
  logic [fpr_pkg::FRAMES_W-1:0]     shadow_frames = fpr_pkg::FRAMES_IN_USE_RESET;

  // Predicted page table and counters.
  logic [fpr_pkg::PAGE_BASE_W-1:0] pt_base [FRAMES_MAX];
  logic [FRAMES_MAX-1:0]           pt_valid;
  logic [fpr_pkg::FRAME_W-1:0]     pt_next;
  logic [fpr_pkg::COUNT_W-1:0]     fault_cnt;
  logic [fpr_pkg::COUNT_W-1:0]     ref_cnt;

  logic [ADDR_W-1:0] pending_addresses [$];
  lookup_t           expected_lookups [$];
  int                words_outstanding = 0;
  int                mismatches = 0;
  int                words_issued = 0;
  int                in_gap = 0;
  int                out_stall = 0;
  int                idle_cycles = 0;
  logic              quiet = 1'b0;

  fifo_page_replacement_unit i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .address         (address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .fault           (fault),
    .frame           (frame),
    .page_base       (page_base),
    .fault_total     (fault_total),
    .reference_total (reference_total),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic [fpr_pkg::COUNT_W-1:0] sat_inc(
      input logic [fpr_pkg::COUNT_W-1:0] v);
    return (v == fpr_pkg::COUNT_MAX) ? v : v + fpr_pkg::COUNT_W'(1);
  endfunction

  // Looks up one address in the predicted table and updates it on a fault.
  function automatic lookup_t predict_lookup(input logic [ADDR_W-1:0] addr);
    logic [32:0]                 psize;
    logic [32:0]                 rem;
    int                          n;
    logic [31:0]                 base;
    logic                        hit;
    logic [fpr_pkg::FRAME_W-1:0] used;
    lookup_t                     r;
    psize = (shadow_page_bytes == '0) ? 33'd1 : {16'd0, shadow_page_bytes};
    n = (shadow_frames == '0) ? 1 :
        ((int'(shadow_frames) > FRAMES_MAX) ? FRAMES_MAX : int'(shadow_frames));
    rem = {1'b0, addr} % psize;
    base = addr - rem[31:0];
    hit = 1'b0;
    used = '0;
    for (int i = 0; i < FRAMES_MAX; i++) begin
      if (!hit && i < n && pt_valid[i] && addr >= pt_base[i] &&
          ({1'b0, addr} - {1'b0, pt_base[i]}) < psize) begin
        hit = 1'b1;
        used = fpr_pkg::FRAME_W'(i);
      end
    end
    ref_cnt = sat_inc(ref_cnt);
    if (!hit) begin
      used = (int'(pt_next) < n) ? pt_next : '0;
      pt_base[used] = base;
      pt_valid[used] = 1'b1;
      pt_next = (int'(used) + 1 >= n) ? '0 : used + fpr_pkg::FRAME_W'(1);
      fault_cnt = sat_inc(fault_cnt);
    end
    r.fault = ~hit;
    r.frame = used;
    r.base = base;
    r.faults = fault_cnt;
    r.refs = ref_cnt;
    return r;
  endfunction

  // Driver: presents queued addresses, predicting each word as it is accepted.
  always @(posedge clk) begin : driver
    logic took;
    logic load;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
      pt_valid = '0;
      pt_next = '0;
      fault_cnt = '0;
      ref_cnt = '0;
    end else begin
      took = in_valid && in_ready;
      if (took) expected_lookups.push_back(predict_lookup(address));
      load = 1'b0;
      if (!in_valid || took) begin
        if (in_gap > 0) in_gap--;
        else if (pending_addresses.size() > 0) load = 1'b1;
      end
      if (load) begin
        address <= pending_addresses.pop_front();
        in_gap = quiet ? 0 : gap_len();
      end
      if (!in_valid || took) in_valid <= load;
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Monitor: compares each result word with the oldest prediction.
  always @(posedge clk) begin : monitor
    lookup_t want;
    if (rst) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_lookups.size() == 0) begin
          $display("%0t: result expected none actual fault %0d frame %0d base %0h",
                   $time, fault, frame, page_base);
          mismatches++;
        end else begin
          want = expected_lookups.pop_front();
          check_field("fault", 32'(want.fault), 32'(fault));
          check_field("frame", 32'(want.frame), 32'(frame));
          check_field("page_base", want.base, page_base);
          check_field("fault_total", want.faults, fault_total);
          check_field("reference_total", want.refs, reference_total);
          words_outstanding--;
        end
      end
      if (quiet) begin
        out_ready <= 1'b1;
      end else if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_stall = gap_len();
      end
    end
  end

  // Watchdog: ends the run when no word moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send(input logic [ADDR_W-1:0] addr);
    words_outstanding++;
    words_issued++;
    pending_addresses.push_back(addr);
  endtask

  // Waits until every queued word has produced its result.
  task automatic drain();
    do @(posedge clk); while (words_outstanding != 0);
  endtask

  task automatic write_reg(input logic [fpr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fpr_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == fpr_pkg::CFG_PAGE_BYTES) shadow_page_bytes = value;
    else shadow_frames = value[fpr_pkg::FRAMES_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [fpr_pkg::PAGE_BYTES_W-1:0] pick_page_bytes();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 17'd1;
      2: return 17'd65536;
      3: return 17'h1FFFF;
      4: return 17'd1 << $urandom_range(1, 16);
      5, 6: return fpr_pkg::PAGE_BYTES_W'($urandom_range(2, 8192));
      default: return fpr_pkg::PAGE_BYTES_W'($urandom);
    endcase
  endfunction

  function automatic logic [fpr_pkg::FRAMES_W-1:0] pick_frames();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 5'd1;
      2: return 5'd16;
      3: return fpr_pkg::FRAMES_W'($urandom_range(17, 31));
      default: return fpr_pkg::FRAMES_W'($urandom_range(2, 15));
    endcase
  endfunction

  // Stimulus: directed cases, then random phases over working sets of pages.
  initial begin
    logic [ADDR_W-1:0]                ws [20];
    logic [ADDR_W-1:0]                region;
    logic [fpr_pkg::PAGE_BYTES_W-1:0] psz;
    int                               eff;
    int                               ws_n;
    int                               count;
    int                               r;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings; a low address must miss on an empty table.
    send(32'h0000_0000);
    send(32'h0000_0FFF);
    send(32'hFFFF_FFFF);
    send(32'h0000_1000);
    send(32'hFFFF_F000);
    drain();

    // Two small pages later covered by one larger page: lowest match wins.
    write_reg(fpr_pkg::CFG_PAGE_BYTES, 17'd16);
    send(32'h0000_0100);
    send(32'h0000_0110);
    drain();
    write_reg(fpr_pkg::CFG_PAGE_BYTES, 17'd256);
    send(32'h0000_0115);
    drain();

    // Lowered rotation: pointer wraps to frame 0, upper frames are not searched.
    write_reg(fpr_pkg::CFG_FRAMES_IN_USE, 17'h1FFE4);
    send(32'h8000_0000);
    send(32'h0000_0100);
    drain();
    write_reg(fpr_pkg::CFG_FRAMES_IN_USE, 17'd3);
    send(32'h0000_0110);
    send(32'hFFFF_FFFF);
    drain();

    // Zero page size and zero frames act as one.
    write_reg(fpr_pkg::CFG_PAGE_BYTES, 17'd0);
    write_reg(fpr_pkg::CFG_FRAMES_IN_USE, 17'd0);
    send(32'd5);
    send(32'd5);
    send(32'd6);
    drain();

    // Largest page size and a frame count beyond the table.
    write_reg(fpr_pkg::CFG_PAGE_BYTES, 17'h1FFFF);
    write_reg(fpr_pkg::CFG_FRAMES_IN_USE, 17'd31);
    send(32'hFFFF_FFFF);
    send(32'd131070);
    send(32'd131071);
    drain();
    write_reg(fpr_pkg::CFG_PAGE_BYTES, 17'd65536);
    write_reg(fpr_pkg::CFG_FRAMES_IN_USE, 17'd16);
    send(32'h0001_FFFF);
    send(32'h0002_0000);
    drain();

    // Random phases.
    while (words_issued < RANDOM_WORDS) begin
      r = $urandom_range(0, 2);
      if (r != 1) write_reg(fpr_pkg::CFG_PAGE_BYTES, pick_page_bytes());
      if (r != 0) begin
        write_reg(fpr_pkg::CFG_FRAMES_IN_USE, {12'($urandom_range(0, 4095)), pick_frames()});
      end
      quiet = ($urandom_range(0, 4) == 0);
      psz = shadow_page_bytes;
      eff = (psz == 0) ? 1 : psz;
      ws_n = $urandom_range(1, 20);
      region = $urandom;
      for (int j = 0; j < ws_n; j++) begin
        if ($urandom_range(0, 1) == 0) ws[j] = region + j * eff;
        else begin
          ws[j] = $urandom;
          ws[j] = ws[j] - (ws[j] % eff);
        end
      end
      count = $urandom_range(20, 100);
      for (int k = 0; k < count; k++) begin
        if ($urandom_range(0, 99) < 15) send($urandom);
        else send(ws[$urandom_range(0, ws_n - 1)] + $urandom_range(0, eff - 1));
      end
      drain();
    end

    quiet = 1'b0;
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_lookups.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
design/fpr_pkg.sv
design/fpr_rem_unit.sv
design/fpr_frame_store.sv
design/fifo_page_replacement_unit.sv
tb/sv/testbench.sv
